FILE: rtl/core/clpd_pkg.sv
// Package for the command/length/payload deframer.
// Holds result kinds, register indexes, queue entry and result word types.
// No dependencies.
package clpd_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [15:0] LIMIT_RESET   = 16'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT = 1'b0,
    REG_LIMIT   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_TOO_BIG = 2'd2,
    KIND_ABANDON = 2'd3
  } kind_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // One classified word on its way from front to back.
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       expired;
  } q_entry_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  frame_code;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
    logic        last;
  } result_t;

endpackage

FILE: rtl/core/clpd_if.sv
// Channel interfaces for the deframer: input words and result words.
// Depends on clpd_pkg.
interface clpd_item_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface clpd_result_if;
  logic                valid;
  logic                ready;
  clpd_pkg::kind_t     kind;
  logic [7:0]          frame_code;
  logic [7:0]          data_byte;
  logic [15:0]         byte_index;
  logic [15:0]         frame_length;
  logic                last;

  modport source (output valid, output kind, output frame_code, output data_byte,
                  output byte_index, output frame_length, output last, input ready);
  modport sink (input valid, input kind, input frame_code, input data_byte,
                input byte_index, input frame_length, input last, output ready);
endinterface

FILE: rtl/core/clpd_queue.sv
// Small register FIFO of classified words between front and back.
// Depends on clpd_pkg.
module clpd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  clpd_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               nonempty,
  output clpd_pkg::q_entry_t head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  clpd_pkg::q_entry_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/clpd_front.sv
// Front end: accepts input words, keeps the idle tick count and tags each
// tick with whether the timeout has been passed. Depends on clpd_pkg.
module clpd_front #(
  parameter int unsigned IDLE_COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_command,
  input  logic [7:0]         item_rx_byte,
  output logic               item_ready,
  input  logic [15:0]        timeout_ticks,
  input  logic               q_full,
  output logic               q_push,
  output clpd_pkg::q_entry_t q_entry
);

  localparam int unsigned CMP_W = (IDLE_COUNT_BITS > 16) ? IDLE_COUNT_BITS : 16;

  logic [IDLE_COUNT_BITS-1:0] idle_count;
  logic [IDLE_COUNT_BITS-1:0] idle_count_next;
  logic                       is_tick;

  assign item_ready = !q_full;
  assign q_push     = item_valid && !q_full;
  assign is_tick    = (item_command == clpd_pkg::OP_TICK);

  always_comb begin
    if (!is_tick) begin
      idle_count_next = '0;
    end else if (&idle_count) begin
      idle_count_next = idle_count;  // saturate
    end else begin
      idle_count_next = idle_count + 1'b1;
    end
  end

  always_comb begin
    q_entry.op      = is_tick ? clpd_pkg::OP_TICK : clpd_pkg::OP_BYTE;
    q_entry.data    = item_rx_byte;
    q_entry.expired = is_tick &&
                      (CMP_W'(idle_count_next) > CMP_W'(timeout_ticks));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_count <= '0;
    end else if (q_push) begin
      idle_count <= idle_count_next;
    end
  end

endmodule

FILE: rtl/core/clpd_back.sv
// Back end: frame parser state machine and the registered result word.
// Depends on clpd_pkg.
module clpd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_nonempty,
  input  clpd_pkg::q_entry_t q_head,
  output logic               q_pop,
  input  logic [15:0]        payload_limit,
  output logic               res_valid,
  input  logic               res_ready,
  output clpd_pkg::result_t  res
);

  typedef enum logic [3:0] {
    PH_CMD     = 4'b0001,
    PH_LEN_LO  = 4'b0010,
    PH_LEN_HI  = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  held_code, held_code_next;
  logic [15:0] held_length, held_length_next;
  logic [15:0] received_count, received_count_next;
  logic        emit;
  clpd_pkg::result_t res_next;
  logic [16:0] idx_inc;

  // Take the head whenever the result register is free or being drained.
  assign q_pop   = q_nonempty && (!res_valid || res_ready);
  assign idx_inc = {1'b0, received_count} + 17'd1;

  always_comb begin
    phase_next          = phase;
    held_code_next      = held_code;
    held_length_next    = held_length;
    received_count_next = received_count;
    emit                = 1'b0;
    res_next            = '0;
    res_next.frame_code = held_code;

    if (q_head.op == clpd_pkg::OP_TICK) begin
      if (phase != PH_CMD && q_head.expired) begin
        phase_next            = PH_CMD;
        emit                  = 1'b1;
        res_next.kind         = clpd_pkg::KIND_ABANDON;
        res_next.byte_index   = received_count;
        res_next.frame_length = held_length;
        res_next.last         = 1'b1;
      end
    end else begin
      case (phase)
        PH_CMD: begin
          held_code_next      = q_head.data;
          held_length_next    = '0;
          received_count_next = '0;
          phase_next          = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          held_length_next = {8'd0, q_head.data};
          phase_next       = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          held_length_next      = {q_head.data, held_length[7:0]};
          received_count_next   = '0;
          res_next.frame_length = held_length_next;
          res_next.last         = 1'b1;
          if (held_length_next == '0) begin
            phase_next    = PH_CMD;
            emit          = 1'b1;
            res_next.kind = clpd_pkg::KIND_EMPTY;
          end else if (held_length_next > payload_limit) begin
            phase_next    = PH_CMD;
            emit          = 1'b1;
            res_next.kind = clpd_pkg::KIND_TOO_BIG;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          emit                  = 1'b1;
          res_next.kind         = clpd_pkg::KIND_BYTE;
          res_next.data_byte    = q_head.data;
          res_next.byte_index   = received_count;
          res_next.frame_length = held_length;
          res_next.last         = (idx_inc >= {1'b0, held_length});
          received_count_next   = idx_inc[15:0];
          if (res_next.last) begin
            phase_next = PH_CMD;
          end
        end
        default: begin
          phase_next = PH_CMD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_CMD;
      held_code      <= '0;
      held_length    <= '0;
      received_count <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (q_pop) begin
        phase          <= phase_next;
        held_code      <= held_code_next;
        held_length    <= held_length_next;
        received_count <= received_count_next;
        res_valid      <= emit;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      res <= res_next;
    end
  end

endmodule

FILE: rtl/core/cmd_length_payload_deframer.sv
// Command/length/payload deframer. Throughput: one word per cycle while the result
// register is free or being drained. An accepted word is written into the queue, and
// the back end then parses it from there and, for a result, loads the result register.
// Reset (rst, synchronous, active high) returns the parser to command wait,
// clears the idle tick count and queue, and loads timeout 500 and limit 4096.
// Depends on clpd_pkg, clpd_if, clpd_queue, clpd_front and clpd_back.
module cmd_length_payload_deframer #(
  parameter int unsigned IDLE_COUNT_BITS = 16,
  parameter int unsigned QUEUE_DEPTH     = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  clpd_item_if.sink                           item,
  clpd_result_if.source                       result,
  input  logic                                cfg_we,
  input  logic [clpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [clpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers; the user must write them only while the block is idle.
  logic [15:0] timeout_ticks;
  logic [15:0] payload_limit;

  // Queue hookup between the front end and the back end.
  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_nonempty;
  clpd_pkg::q_entry_t q_entry;
  clpd_pkg::q_entry_t q_head;
  clpd_pkg::result_t  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= clpd_pkg::TIMEOUT_RESET;
      payload_limit <= clpd_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (clpd_pkg::cfg_reg_t'(cfg_index))
        clpd_pkg::REG_TIMEOUT: timeout_ticks <= cfg_data;
        clpd_pkg::REG_LIMIT:   payload_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: accept words, track idle ticks, flag expired ticks.
  clpd_front #(
    .IDLE_COUNT_BITS (IDLE_COUNT_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item.valid),
    .item_command  (item.command),
    .item_rx_byte  (item.rx_byte),
    .item_ready    (item.ready),
    .timeout_ticks (timeout_ticks),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  // Hold classified words so the front keeps accepting during output stalls until full.
  clpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .nonempty   (q_nonempty),
    .head       (q_head)
  );

  // Back: advance the frame parser and register one result word.
  clpd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_nonempty    (q_nonempty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .payload_limit (payload_limit),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res           (res)
  );

  assign result.kind         = res.kind;
  assign result.frame_code   = res.frame_code;
  assign result.data_byte    = res.data_byte;
  assign result.byte_index   = res.byte_index;
  assign result.frame_length = res.frame_length;
  assign result.last         = res.last;

  // Every result other than a payload byte closes its frame.
  a_nonbyte_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.kind != clpd_pkg::KIND_BYTE |-> result.last)
    else $error("non-payload result without last");

  // A payload byte always lies inside the declared length.
  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.kind == clpd_pkg::KIND_BYTE |->
      result.byte_index < result.frame_length)
    else $error("payload index beyond frame length");

  // Only payload bytes carry data.
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.kind != clpd_pkg::KIND_BYTE |-> result.data_byte == 8'd0)
    else $error("data on a non-payload result");

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");

endmodule

FILE: verif/testbench.sv
// Self-checking bench for cmd_length_payload_deframer: drives byte and tick words,
// predicts every result word in a cycle-free deframer model and compares them.
// Depends on clpd_pkg, clpd_if and the deframer RTL.
module testbench;
  import clpd_pkg::*;

  localparam int unsigned IDLE_BITS     = 16;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PRINT_CAP     = 50;

  typedef enum logic [1:0] {
    WAIT_CODE,
    WAIT_LEN_LO,
    WAIT_LEN_HI,
    WAIT_BODY
  } parse_phase_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] value;
  } stim_word_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  clpd_item_if   item_ch ();
  clpd_result_if result_ch ();

  cmd_length_payload_deframer #(
    .IDLE_COUNT_BITS(IDLE_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Words waiting for the driver, and result words the deframer owes us.
  stim_word_t words_to_send[$];
  result_t    predicted_results[$];

  // Deframer state as the bench sees it, plus its copy of both registers.
  parse_phase_t         parse_phase = WAIT_CODE;
  logic [7:0]           held_code = '0;
  logic [15:0]          held_length = '0;
  logic [15:0]          byte_count = '0;
  logic [IDLE_BITS-1:0] idle_ticks = '0;
  logic [15:0]          timeout_reg = TIMEOUT_RESET;
  logic [15:0]          limit_reg = LIMIT_RESET;

  // Driver bookkeeping: the word on the bus is held until it is taken.
  stim_word_t  on_bus;
  bit          word_held = 1'b0;
  int unsigned gap_pct = 15;

  int unsigned mismatch_count = 0;
  int unsigned words_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned budget = 0;
  int unsigned kinds_seen[4] = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  task automatic add_result(input kind_t kind, input logic [7:0] data,
                            input logic [15:0] index, input logic last);
    result_t r;
    r.kind         = kind;
    r.frame_code   = held_code;
    r.data_byte    = data;
    r.byte_index   = index;
    r.frame_length = held_length;
    r.last         = last;
    predicted_results.push_back(r);
  endtask

  // Advance the deframer by one accepted word and queue any result it owes.
  task automatic deframe_word(input op_t op, input logic [7:0] value);
    logic [16:0] next_count;
    logic        last;
    if (op == OP_TICK) begin
      // Ticks count in every phase and saturate; the count is kept after abandon.
      if (idle_ticks != '1)
        idle_ticks++;
      if (parse_phase != WAIT_CODE && idle_ticks > timeout_reg) begin
        parse_phase = WAIT_CODE;
        add_result(KIND_ABANDON, 8'h00, byte_count, 1'b1);
      end
    end else begin
      idle_ticks = '0;
      case (parse_phase)
        WAIT_CODE: begin
          held_code   = value;
          held_length = '0;
          byte_count  = '0;
          parse_phase = WAIT_LEN_LO;
        end
        WAIT_LEN_LO: begin
          held_length = {8'h00, value};
          parse_phase = WAIT_LEN_HI;
        end
        WAIT_LEN_HI: begin
          held_length = {value, held_length[7:0]};
          byte_count  = '0;
          // Zero length wins over the limit check, even with a zero limit.
          if (held_length == '0) begin
            parse_phase = WAIT_CODE;
            add_result(KIND_EMPTY, 8'h00, 16'h0000, 1'b1);
          end else if (held_length > limit_reg) begin
            parse_phase = WAIT_CODE;
            add_result(KIND_TOO_BIG, 8'h00, 16'h0000, 1'b1);
          end else begin
            parse_phase = WAIT_BODY;
          end
        end
        default: begin
          next_count = {1'b0, byte_count} + 17'd1;
          last       = (next_count >= {1'b0, held_length});
          add_result(KIND_BYTE, value, byte_count, last);
          byte_count = next_count[15:0];
          if (last)
            parse_phase = WAIT_CODE;
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the next word, hold it until taken, gap at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      word_held = 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        deframe_word(on_bus.op, on_bus.value);
        words_sent++;
        word_held = 1'b0;
      end
      if (!word_held && words_to_send.size() != 0 && $urandom_range(99) >= gap_pct) begin
        on_bus = words_to_send.pop_front();
        word_held = 1'b1;
        item_ch.command <= on_bus.op;
        item_ch.rx_byte <= on_bus.value;
      end
      // Single assignment per edge: valid stays high across back-to-back words.
      item_ch.valid <= word_held;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall at random, compare each taken result with the oldest one owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin : take_result
        result_t want;
        if (predicted_results.size() == 0) begin
          flag_mismatch("result with nothing owed, kind", result_ch.kind, 0);
        end else begin
          want = predicted_results.pop_front();
          if (result_ch.kind !== want.kind)
            flag_mismatch("kind", result_ch.kind, want.kind);
          if (result_ch.frame_code !== want.frame_code)
            flag_mismatch("frame_code", result_ch.frame_code, want.frame_code);
          if (result_ch.data_byte !== want.data_byte)
            flag_mismatch("data_byte", result_ch.data_byte, want.data_byte);
          if (result_ch.byte_index !== want.byte_index)
            flag_mismatch("byte_index", result_ch.byte_index, want.byte_index);
          if (result_ch.frame_length !== want.frame_length)
            flag_mismatch("frame_length", result_ch.frame_length, want.frame_length);
          if (result_ch.last !== want.last)
            flag_mismatch("last", result_ch.last, want.last);
          kinds_seen[want.kind]++;
        end
      end
      result_ch.ready <= ($urandom_range(99) >= gap_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_word(input op_t op, input logic [7:0] value);
    words_to_send.push_back('{op, value});
    budget++;
  endtask

  // Tick bytes are random too: the deframer must ignore them.
  task automatic push_ticks(input int unsigned n);
    repeat (n) words_to_send.push_back('{OP_TICK, 8'($urandom)});
    budget += n;
  endtask

  task automatic push_header(input logic [7:0] code, input logic [7:0] lo,
                             input logic [7:0] hi);
    push_word(OP_BYTE, code);
    push_word(OP_BYTE, lo);
    push_word(OP_BYTE, hi);
  endtask

  // Hold until the bench owes nothing and the deframer has drained its queue.
  task automatic settle();
    do @(posedge clk);
    while (words_to_send.size() != 0 || word_held || predicted_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t index, input logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == REG_TIMEOUT)
      timeout_reg = value;
    else
      limit_reg = value;
    reg_writes++;
  endtask

  task automatic set_config(input logic [15:0] timeout, input logic [15:0] limit);
    settle();
    write_reg(REG_TIMEOUT, timeout);
    write_reg(REG_LIMIT, limit);
  endtask

  // Mostly short valid lengths; some zero, some oversize, some exactly at the limit.
  function automatic logic [15:0] pick_length();
    int unsigned r;
    int unsigned cap;
    r   = $urandom_range(99);
    cap = (limit_reg < 12) ? limit_reg : 12;
    if (r < 10)
      return '0;
    if (r < 22 && limit_reg != 16'hFFFF)
      return 16'($urandom_range(65535, limit_reg + 1));
    if (r < 27 && limit_reg <= 300)
      return limit_reg;
    if (cap == 0)
      return '0;
    return 16'($urandom_range(cap, 1));
  endfunction

  // Send one frame, or only its first keep words when keep is not negative.
  // Tick runs inside the frame never reach the timeout.
  task automatic push_frame(input logic [15:0] len, input int keep);
    logic [7:0]  frame[$];
    int unsigned body;
    int unsigned tick_cap;
    int          n;
    body     = (len == 0 || len > limit_reg) ? 0 : len;
    tick_cap = (timeout_reg < 6) ? timeout_reg : 6;
    frame.push_back(8'($urandom));
    frame.push_back(len[7:0]);
    frame.push_back(len[15:8]);
    repeat (body) frame.push_back(8'($urandom));
    n = (keep < 0 || keep > frame.size()) ? frame.size() : keep;
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(99) < 15)
        push_ticks($urandom_range(tick_cap, 0));
      push_word(OP_BYTE, frame[i]);
    end
  endtask

  // Mostly whole frames; the rest truncated frames, noise and loose tick runs.
  // Truncation and noise are followed by enough ticks to force a resync, so
  // they are only used where the timeout is short enough to afford that.
  task automatic random_phase(input int unsigned target);
    int unsigned r;
    int unsigned run_cap;
    logic [15:0] len;
    bit          cheap_resync;
    budget       = 0;
    cheap_resync = (timeout_reg < 64);
    run_cap      = (timeout_reg + 3 < 40) ? timeout_reg + 3 : 40;
    while (budget < target) begin
      r   = $urandom_range(99);
      len = pick_length();
      if (r < 70 || (r < 90 && !cheap_resync)) begin
        push_frame(len, -1);
      end else if (r < 80) begin
        push_frame(len, $urandom_range(2 + ((len > 12) ? 12 : len), 1));
        push_ticks(timeout_reg + 1);
      end else if (r < 90) begin
        repeat ($urandom_range(5, 1)) push_word(op_t'($urandom_range(1)), 8'($urandom));
        push_ticks(timeout_reg + 1);
      end else begin
        push_ticks($urandom_range(run_cap, 1));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    item_ch.valid   = 1'b0;
    item_ch.command = 1'b0;
    item_ch.rx_byte = 8'h00;
    result_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset registers: one-byte frame with extreme code and data,
    // empty frame, length one above the limit, a tick while waiting for a
    // command, and a tick inside a frame that stays under the timeout.
    push_header(8'hFF, 8'h01, 8'h00);
    push_word(OP_BYTE, 8'h00);
    push_header(8'h00, 8'h00, 8'h00);
    push_header(8'hA5, 8'h01, 8'h10);
    push_word(OP_TICK, 8'hFF);
    push_header(8'h5A, 8'h02, 8'h00);
    push_word(OP_BYTE, 8'hFF);
    push_word(OP_TICK, 8'h00);
    push_word(OP_BYTE, 8'h80);

    // Directed, zero timeout and zero limit: abandon after the command byte
    // only, abandon with just the low length byte held, reject a length of one.
    set_config(16'h0000, 16'h0000);
    push_word(OP_BYTE, 8'hC3);
    push_word(OP_TICK, 8'h00);
    push_word(OP_BYTE, 8'h3C);
    push_word(OP_BYTE, 8'h07);
    push_word(OP_TICK, 8'h5A);
    push_header(8'h22, 8'h01, 8'h00);

    set_config(16'd3, 16'd8);
    random_phase(270);
    set_config(16'h0000, 16'h0000);
    random_phase(270);

    // Widest registers, with no gaps on either side for the whole phase.
    set_config(16'hFFFF, 16'hFFFF);
    gap_pct = 0;
    random_phase(270);
    gap_pct = 15;

    set_config(16'd1, 16'd300);
    random_phase(270);
    set_config(TIMEOUT_RESET, LIMIT_RESET);
    random_phase(270);
    set_config(16'd12, 16'd1);
    random_phase(270);

    settle();
    $display("covered %0d words over %0d register writes: %0d payload, %0d empty,",
             words_sent, reg_writes, kinds_seen[KIND_BYTE], kinds_seen[KIND_EMPTY]);
    $display("  %0d oversize and %0d abandoned results checked, %0d mismatches",
             kinds_seen[KIND_TOO_BIG], kinds_seen[KIND_ABANDON], mismatch_count);
    if (mismatch_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
